FILE: sv/arpp_pkg.sv
// Shared types and constants for the audio ring PWM player.
package arpp_pkg;

   localparam int unsigned RING_DEPTH_DEF = 2048;

   localparam int unsigned ACTION_W  = 3;
   localparam int unsigned SAMPLE_W  = 8;
   localparam int unsigned DUTY_W    = 15;
   localparam int unsigned GAIN_W    = 9;
   localparam int unsigned BITS_W    = 4;
   localparam int unsigned CSR_AW    = 3;
   localparam int unsigned CSR_DW    = 32;

   localparam logic [SAMPLE_W-1:0] SILENCE   = 8'd128;
   localparam logic [GAIN_W-1:0]   GAIN_UNITY = 9'd256;
   localparam logic [BITS_W-1:0]   BITS_MIN  = 4'd2;
   localparam logic [BITS_W-1:0]   BITS_RST  = 4'd8;

   typedef enum logic [ACTION_W-1:0] {
      ACT_WRITE = 3'd0,
      ACT_TICK  = 3'd1,
      ACT_END   = 3'd2,
      ACT_START = 3'd3,
      ACT_STOP  = 3'd4
   } action_type;

   typedef enum logic {
      REG_GAIN = 1'b0,
      REG_BITS = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic exec;
      logic mul1;
      logic mul2;
      logic div;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic [GAIN_W-1:0] volume_gain;
      logic [BITS_W-1:0] pwm_bits;
   } cfg_type;

endpackage

FILE: sv/arpp_channels.sv
// Request and response channel interfaces of the audio ring PWM player.
interface arpp_req_if;
   import arpp_pkg::*;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [SAMPLE_W-1:0] sample_byte;
   modport source (output valid, action, sample_byte, input ready);
   modport sink (input valid, action, sample_byte, output ready);
endinterface

interface arpp_rsp_if;
   import arpp_pkg::*;
   logic              valid;
   logic              ready;
   logic [DUTY_W-1:0] duty;
   logic              duty_update;
   logic              sample_accepted;
   logic              playing;
   logic              underrun;
   logic              stream_done;
   modport source (output valid, duty, duty_update, sample_accepted, playing, underrun,
                   stream_done, input ready);
   modport sink (input valid, duty, duty_update, sample_accepted, playing, underrun,
                 stream_done, output ready);
endinterface

FILE: sv/arpp_csr.sv
// APB register file: volume gain and PWM resolution.
module arpp_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [arpp_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [arpp_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [arpp_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready,
   output arpp_pkg::cfg_type             cfg
);
   import arpp_pkg::*;

   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic [BITS_W-1:0] bits_ff, bits_in;
   logic              wr_en;
   reg_index_type     idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign idx        = reg_index_type'(csr_paddr[2]);

   always_comb begin
      gain_in = gain_ff;
      bits_in = bits_ff;
      if (wr_en) begin
         case (idx)
            REG_GAIN: gain_in = csr_pwdata[GAIN_W-1:0];
            REG_BITS: bits_in = csr_pwdata[BITS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_UNITY;
         bits_ff <= BITS_RST;
      end else begin
         gain_ff <= gain_in;
         bits_ff <= bits_in;
      end
   end

   always_comb begin
      case (idx)
         REG_GAIN: csr_prdata = {{(CSR_DW-GAIN_W){1'b0}}, gain_ff};
         REG_BITS: csr_prdata = {{(CSR_DW-BITS_W){1'b0}}, bits_ff};
         default:  csr_prdata = '0;
      endcase
   end

   assign cfg.volume_gain = gain_ff;
   assign cfg.pwm_bits    = bits_ff;

endmodule

FILE: sv/arpp_ctrl.sv
// Controller: sequences one request through the datapath and owns response valid.
module arpp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output arpp_pkg::cmd_type cmd
);
   import arpp_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.exec = 1'b1;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> rsp_valid_ff)
      else $error("response not valid after load");
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_MUL1))
      else $error("accepted request did not start processing");
`endif

endmodule

FILE: sv/arpp_dp.sv
// Datapath: sample ring, playback flags, volume scaling and duty mapping.
module arpp_dp #(
   parameter int unsigned RING_DEPTH = arpp_pkg::RING_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  arpp_pkg::cmd_type             cmd,
   input  arpp_pkg::cfg_type             cfg,
   input  logic [arpp_pkg::ACTION_W-1:0] req_action,
   input  logic [arpp_pkg::SAMPLE_W-1:0] req_sample_byte,
   output logic [arpp_pkg::DUTY_W-1:0]   rsp_duty,
   output logic                          rsp_duty_update,
   output logic                          rsp_sample_accepted,
   output logic                          rsp_playing,
   output logic                          rsp_underrun,
   output logic                          rsp_stream_done
);
   import arpp_pkg::*;

   localparam int unsigned AW = $clog2(RING_DEPTH);
   localparam int unsigned FW = $clog2(RING_DEPTH + 1);
   localparam logic [AW-1:0] PTR_LAST = AW'(RING_DEPTH - 1);
   localparam logic [FW-1:0] FILL_MAX = FW'(RING_DEPTH);

   logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
   logic [SAMPLE_W-1:0] rd_q;
   logic                mem_we, mem_re;

   logic [AW-1:0] rp_ff, rp_in, wp_ff, wp_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic          ended_ff, ended_in, active_ff, active_in;
   logic          upd_ff, upd_in, acc_ff, acc_in, under_ff, under_in;
   logic          done_ff, done_in, use_mem_ff, use_mem_in;

   // request decode and ring update
   always_comb begin
      rp_in      = rp_ff;
      wp_in      = wp_ff;
      fill_in    = fill_ff;
      ended_in   = ended_ff;
      active_in  = active_ff;
      upd_in     = upd_ff;
      acc_in     = acc_ff;
      under_in   = under_ff;
      done_in    = done_ff;
      use_mem_in = use_mem_ff;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      if (cmd.exec) begin
         upd_in     = 1'b0;
         acc_in     = 1'b0;
         under_in   = 1'b0;
         done_in    = 1'b0;
         use_mem_in = 1'b0;
         case (action_type'(req_action))
            ACT_WRITE: begin
               if (fill_ff < FILL_MAX) begin
                  mem_we  = 1'b1;
                  wp_in   = (wp_ff == PTR_LAST) ? '0 : wp_ff + 1'b1;
                  fill_in = fill_ff + 1'b1;
                  acc_in  = 1'b1;
               end
            end
            ACT_TICK: begin
               if (active_ff) begin
                  upd_in = 1'b1;
                  if (fill_ff != '0) begin
                     mem_re     = 1'b1;
                     use_mem_in = 1'b1;
                     rp_in      = (rp_ff == PTR_LAST) ? '0 : rp_ff + 1'b1;
                     fill_in    = fill_ff - 1'b1;
                     if (fill_ff == FW'(1) && ended_ff) begin
                        active_in = 1'b0;
                        done_in   = 1'b1;
                     end
                  end else if (ended_ff) begin
                     active_in = 1'b0;
                     done_in   = 1'b1;
                  end else begin
                     under_in = 1'b1;
                  end
               end
            end
            ACT_END: ended_in = 1'b1;
            ACT_START: begin
               rp_in     = '0;
               wp_in     = '0;
               fill_in   = '0;
               ended_in  = 1'b0;
               active_in = 1'b1;
               upd_in    = 1'b1;
            end
            ACT_STOP: begin
               done_in   = active_ff;
               rp_in     = '0;
               wp_in     = '0;
               fill_in   = '0;
               ended_in  = 1'b1;
               active_in = 1'b0;
               upd_in    = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff      <= '0;
         wp_ff      <= '0;
         fill_ff    <= '0;
         ended_ff   <= 1'b0;
         active_ff  <= 1'b0;
         upd_ff     <= 1'b0;
         acc_ff     <= 1'b0;
         under_ff   <= 1'b0;
         done_ff    <= 1'b0;
         use_mem_ff <= 1'b0;
      end else begin
         rp_ff      <= rp_in;
         wp_ff      <= wp_in;
         fill_ff    <= fill_in;
         ended_ff   <= ended_in;
         active_ff  <= active_in;
         upd_ff     <= upd_in;
         acc_ff     <= acc_in;
         under_ff   <= under_in;
         done_ff    <= done_in;
         use_mem_ff <= use_mem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[wp_ff] <= req_sample_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_q <= ring_mem[rp_ff];
      end
   end

   // volume: centered sample times gain
   logic [SAMPLE_W-1:0]  smp;
   logic [GAIN_W-1:0]    gain_eff;
   logic signed [8:0]    ctr;
   logic signed [18:0]   mul1_w;
   logic signed [16:0]   prod1_ff, prod1_in;

   always_comb begin
      smp      = use_mem_ff ? rd_q : SILENCE;
      gain_eff = (cfg.volume_gain > GAIN_UNITY) ? GAIN_UNITY : cfg.volume_gain;
      ctr      = $signed({1'b0, smp}) - 9'sd128;
      mul1_w   = ctr * $signed({1'b0, gain_eff});
      prod1_in = $signed(mul1_w[16:0]);
   end

   // truncate toward zero, re-center, clamp, times full scale
   logic signed [16:0]  adj;
   logic signed [8:0]   quo;
   logic signed [9:0]   lvl;
   logic [7:0]          lvl_c;
   logic [BITS_W-1:0]   bits_eff;
   logic [15:0]         full_w;
   logic [DUTY_W-1:0]   full;
   logic [22:0]         prod2_ff, prod2_in;

   always_comb begin
      adj      = prod1_ff[16] ? prod1_ff + 17'sd255 : prod1_ff;
      quo      = adj[16:8];
      lvl      = {quo[8], quo} + 10'sd128;
      if (lvl < 10'sd0) begin
         lvl_c = 8'd0;
      end else if (lvl > 10'sd255) begin
         lvl_c = 8'd255;
      end else begin
         lvl_c = lvl[7:0];
      end
      bits_eff = (cfg.pwm_bits < BITS_MIN) ? BITS_MIN : cfg.pwm_bits;
      full_w   = (16'd1 << bits_eff) - 16'd1;
      full     = full_w[DUTY_W-1:0];
      prod2_in = {15'd0, lvl_c} * {8'd0, full};
   end

   // divide by 255: reciprocal 0x01010101 as shifted adds, one correction step
   logic [23:0]       num_ff, num_in;
   logic [48:0]       rsum;
   logic [DUTY_W-1:0] q0_ff, q0_in;

   always_comb begin
      num_in = {1'b0, prod2_ff} + 24'd127;
      rsum   = {25'd0, num_in} + {17'd0, num_in, 8'd0} + {9'd0, num_in, 16'd0}
             + {1'b0, num_in, 24'd0};
      q0_in  = rsum[46:32];
   end

   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         prod1_ff <= prod1_in;
      end
      if (cmd.mul2) begin
         prod2_ff <= prod2_in;
      end
      if (cmd.div) begin
         num_ff <= num_in;
         q0_ff  <= q0_in;
      end
   end

   logic [23:0]       rem;
   logic [DUTY_W-1:0] duty_val;

   always_comb begin
      rem      = num_ff - {1'b0, q0_ff, 8'd0} + {9'd0, q0_ff};
      duty_val = (rem >= 24'd255) ? q0_ff + 1'b1 : q0_ff;
   end

   logic [DUTY_W-1:0] out_duty_ff;
   logic              out_upd_ff, out_acc_ff, out_play_ff, out_under_ff, out_done_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_duty_ff  <= upd_ff ? duty_val : '0;
         out_upd_ff   <= upd_ff;
         out_acc_ff   <= acc_ff;
         out_play_ff  <= active_ff;
         out_under_ff <= under_ff;
         out_done_ff  <= done_ff;
      end
   end

   assign rsp_duty            = out_duty_ff;
   assign rsp_duty_update     = out_upd_ff;
   assign rsp_sample_accepted = out_acc_ff;
   assign rsp_playing         = out_play_ff;
   assign rsp_underrun        = out_under_ff;
   assign rsp_stream_done     = out_done_ff;

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_MAX)
      else $error("fill count above ring depth");
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> (rp_ff == wp_ff))
      else $error("empty ring with unequal pointers");
   a_under_active: assert property (@(posedge clock) disable iff (reset)
      under_ff |-> (upd_ff && active_ff))
      else $error("underrun outside active playback");
   a_done_stops: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !active_ff)
      else $error("stream done while still active");
`endif

endmodule

FILE: sv/audio_ring_pwm_player.sv
// Top level of the audio ring PWM player.
//
//  channel   direction  handshake              contents
//  req_ch    in         valid/ready            action, sample_byte
//  rsp_ch    out        valid/ready            duty and status flags, one per request
//  csr_*     in         APB psel/penable       volume_gain @0x0, pwm_bits @0x4
//
// Each request passes through these steps in order: accept and ring update, gain multiply,
// full-scale multiply, divide by 255, response load.
// The ring is one memory port pair; a popped sample is read in the accept cycle.
// Synchronous reset empties the ring and stops playback; ring contents are not cleared.
// A stalled response holds the controller in its last step; the next request is
// accepted while the previous response still waits.
module audio_ring_pwm_player #(
   parameter int unsigned RING_DEPTH = arpp_pkg::RING_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   arpp_req_if.sink                    req_ch,
   arpp_rsp_if.source                  rsp_ch,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [arpp_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [arpp_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [arpp_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   import arpp_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   logic    req_ready, rsp_valid;

   arpp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   arpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   arpp_dp #(
      .RING_DEPTH (RING_DEPTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .cfg                 (cfg),
      .req_action          (req_ch.action),
      .req_sample_byte     (req_ch.sample_byte),
      .rsp_duty            (rsp_ch.duty),
      .rsp_duty_update     (rsp_ch.duty_update),
      .rsp_sample_accepted (rsp_ch.sample_accepted),
      .rsp_playing         (rsp_ch.playing),
      .rsp_underrun        (rsp_ch.underrun),
      .rsp_stream_done     (rsp_ch.stream_done)
   );

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;

endmodule

FILE: tb/audio_ring_pwm_player_checker.sv
// Request/response monitor, playback predictor and comparator for the audio ring PWM player.
module audio_ring_pwm_player_checker #(
   parameter int unsigned RING_DEPTH = arpp_pkg::RING_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   arpp_req_if                         req_ch,
   arpp_rsp_if                         rsp_ch,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic                        csr_pready,
   input  logic [arpp_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [arpp_pkg::CSR_DW-1:0] csr_pwdata,
   output int                          error_count,
   output int                          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import arpp_pkg::*;

   typedef struct packed {
      logic [DUTY_W-1:0] duty;
      logic              duty_update;
      logic              sample_accepted;
      logic              playing;
      logic              underrun;
      logic              stream_done;
   } player_result_type;

   logic [SAMPLE_W-1:0] ring_model [RING_DEPTH];
   int unsigned         rd_ptr;
   int unsigned         wr_ptr;
   int unsigned         fill;
   logic                data_ended;
   logic                running;
   logic [GAIN_W-1:0]   gain_reg;
   logic [BITS_W-1:0]   bits_reg;
   player_result_type   expected_outputs [$];

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   task automatic report_error(input string msg);
      $display("%0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic compare_field(input string name, input logic [DUTY_W-1:0] got,
                                input logic [DUTY_W-1:0] want);
      if (got !== want) begin
         report_error($sformatf("%s mismatch: got %0d expected %0d", name, got, want));
      end
   endtask

   // center on silence, apply gain (truncating toward zero), clamp, map to full scale
   function automatic logic [DUTY_W-1:0] duty_for_sample(input logic [SAMPLE_W-1:0] s);
      int g;
      int lvl;
      int nbits;
      int full;
      g = (gain_reg > GAIN_UNITY) ? int'(GAIN_UNITY) : int'(gain_reg);
      lvl = (int'(s) - int'(SILENCE)) * g / 256 + int'(SILENCE);
      if (lvl < 0) lvl = 0;
      if (lvl > 255) lvl = 255;
      nbits = (bits_reg < BITS_MIN) ? int'(BITS_MIN) : int'(bits_reg);
      full = (1 << nbits) - 1;
      return DUTY_W'((lvl * full + 127) / 255);
   endfunction

   function automatic player_result_type predict_player_output(
         input logic [ACTION_W-1:0] act, input logic [SAMPLE_W-1:0] smp);
      player_result_type   res;
      logic [SAMPLE_W-1:0] level;
      res = '0;
      case (act)
         ACT_WRITE: begin
            if (fill < RING_DEPTH) begin
               ring_model[wr_ptr] = smp;
               wr_ptr = (wr_ptr + 1) % RING_DEPTH;
               fill++;
               res.sample_accepted = 1'b1;
            end
         end
         ACT_TICK: begin
            if (running) begin
               level = SILENCE;
               if (fill > 0) begin
                  level = ring_model[rd_ptr];
                  rd_ptr = (rd_ptr + 1) % RING_DEPTH;
                  fill--;
                  if (fill == 0 && data_ended) begin
                     running = 1'b0;
                     res.stream_done = 1'b1;
                  end
               end else if (data_ended) begin
                  running = 1'b0;
                  res.stream_done = 1'b1;
               end else begin
                  res.underrun = 1'b1;
               end
               res.duty = duty_for_sample(level);
               res.duty_update = 1'b1;
            end
         end
         ACT_END: begin
            data_ended = 1'b1;
         end
         ACT_START: begin
            rd_ptr = 0;
            wr_ptr = 0;
            fill = 0;
            data_ended = 1'b0;
            running = 1'b1;
            res.duty = duty_for_sample(SILENCE);
            res.duty_update = 1'b1;
         end
         ACT_STOP: begin
            res.stream_done = running;
            rd_ptr = 0;
            wr_ptr = 0;
            fill = 0;
            data_ended = 1'b1;
            running = 1'b0;
            res.duty = duty_for_sample(SILENCE);
            res.duty_update = 1'b1;
         end
         default: begin
         end
      endcase
      res.playing = running;
      return res;
   endfunction

   always @(posedge clock) begin
      player_result_type want;
      if (reset) begin
         rd_ptr = 0;
         wr_ptr = 0;
         fill = 0;
         data_ended = 1'b0;
         running = 1'b0;
         gain_reg = GAIN_UNITY;
         bits_reg = BITS_RST;
         expected_outputs.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == {REG_GAIN, 2'b00}) gain_reg = csr_pwdata[GAIN_W-1:0];
            if (csr_paddr == {REG_BITS, 2'b00}) bits_reg = csr_pwdata[BITS_W-1:0];
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_outputs.push_back(predict_player_output(req_ch.action, req_ch.sample_byte));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_outputs.size() == 0) begin
               report_error("response with no request outstanding");
            end else begin
               want = expected_outputs.pop_front();
               compare_field("duty", rsp_ch.duty, want.duty);
               compare_field("duty_update", rsp_ch.duty_update, want.duty_update);
               compare_field("sample_accepted", rsp_ch.sample_accepted, want.sample_accepted);
               compare_field("playing", rsp_ch.playing, want.playing);
               compare_field("underrun", rsp_ch.underrun, want.underrun);
               compare_field("stream_done", rsp_ch.stream_done, want.stream_done);
            end
         end
      end
      pending_count <= expected_outputs.size();
   end

endmodule

FILE: tb/audio_ring_pwm_player_test.sv
// Stimulus, clocking and verdict for the audio ring PWM player testbench.
module audio_ring_pwm_player_test;
   timeunit 1ns;
   timeprecision 1ps;

   import arpp_pkg::*;

   localparam int unsigned RING_DEPTH      = RING_DEPTH_DEF;
   localparam int          RANDOM_REQUESTS = 1250;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   int error_count;
   int pending_count;
   int requests_sent = 0;
   bit no_idle = 1'b0;

   arpp_req_if req_ch ();
   arpp_rsp_if rsp_ch ();

   audio_ring_pwm_player #(
      .RING_DEPTH(RING_DEPTH)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   audio_ring_pwm_player_checker #(
      .RING_DEPTH(RING_DEPTH)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_pready    (csr_pready),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #16_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      if ($urandom_range(0, 3) != 0) return SAMPLE_W'($urandom_range(0, 255));
      case ($urandom_range(0, 6))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd127;
         3: return SILENCE;
         4: return 8'd129;
         5: return 8'd254;
         default: return 8'd255;
      endcase
   endfunction

   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      forever begin
         stall = no_idle ? 0 : pick_gap();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   task automatic send_request(input logic [ACTION_W-1:0] act, input logic [SAMPLE_W-1:0] smp);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.action      <= act;
      req_ch.sample_byte <= smp;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (act <= ACT_STOP) requests_sent++;
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [CSR_DW-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // drop valid and let every outstanding response drain
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // start, interleaved writes and ticks, end of data, then drain to done
   task automatic play_stream();
      int total;
      int written;
      int queued;
      int r;
      total = $urandom_range(1, 40);
      written = 0;
      queued = 0;
      send_request(ACT_START, pick_sample());
      while (written < total) begin
         r = $urandom_range(0, 99);
         if (r < 55 || (queued == 0 && r < 85)) begin
            send_request(ACT_WRITE, pick_sample());
            written++;
            queued++;
         end else begin
            send_request(ACT_TICK, pick_sample());
            if (queued > 0) queued--;
         end
      end
      send_request(ACT_END, pick_sample());
      repeat ((queued == 0) ? 1 : queued) send_request(ACT_TICK, pick_sample());
      repeat ($urandom_range(0, 2)) send_request(ACT_TICK, pick_sample());
   endtask

   task automatic broken_stream();
      if ($urandom_range(0, 1)) send_request(ACT_START, pick_sample());
      repeat ($urandom_range(0, 12)) begin
         send_request($urandom_range(0, 1) ? ACT_WRITE : ACT_TICK, pick_sample());
      end
      case ($urandom_range(0, 2))
         0: send_request(ACT_STOP, pick_sample());
         1: send_request(ACT_START, pick_sample());
         default: send_request(ACT_END, pick_sample());
      endcase
      repeat ($urandom_range(0, 3)) send_request(ACT_TICK, pick_sample());
   endtask

   task automatic noise_burst();
      repeat ($urandom_range(5, 15)) begin
         send_request(ACTION_W'($urandom_range(0, 7)), pick_sample());
      end
   endtask

   // overfill the ring, then drain it completely so both pointers wrap
   task automatic fill_ring();
      send_request(ACT_START, pick_sample());
      repeat (RING_DEPTH + 3) send_request(ACT_WRITE, pick_sample());
      send_request(ACT_END, pick_sample());
      repeat (RING_DEPTH) send_request(ACT_TICK, pick_sample());
      send_request(ACT_TICK, pick_sample());
   endtask

   initial begin
      int phase;
      int r;
      int saved;
      logic [GAIN_W-1:0] gain;
      logic [BITS_W-1:0] bits;

      req_ch.valid       <= 1'b0;
      req_ch.action      <= ACT_WRITE;
      req_ch.sample_byte <= '0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // idle behavior and unused codes
      send_request(ACT_TICK, 8'd0);
      send_request(ACT_END, 8'd255);
      send_request(ACT_STOP, 8'd0);
      send_request(ACT_WRITE, 8'd200);
      send_request(3'd5, 8'd255);
      send_request(3'd6, 8'd0);
      send_request(3'd7, 8'd170);
      // extremes through the default gain, then underrun
      send_request(ACT_START, 8'd85);
      send_request(ACT_WRITE, 8'd0);
      send_request(ACT_WRITE, 8'd255);
      send_request(ACT_WRITE, SILENCE);
      send_request(ACT_WRITE, 8'd127);
      repeat (5) send_request(ACT_TICK, 8'd0);
      // pop that empties the ring after end of data ends playback
      send_request(ACT_WRITE, 8'd1);
      send_request(ACT_END, 8'd0);
      send_request(ACT_TICK, 8'd0);
      send_request(ACT_TICK, 8'd0);
      // empty ring after end of data: done without underrun
      send_request(ACT_START, 8'd0);
      send_request(ACT_END, 8'd0);
      send_request(ACT_TICK, 8'd0);
      // stop while playing
      send_request(ACT_START, 8'd0);
      send_request(ACT_WRITE, 8'd64);
      send_request(ACT_STOP, 8'd0);

      requests_sent = 0;
      phase = 0;
      while (requests_sent < RANDOM_REQUESTS) begin
         settle();
         case (phase)
            0: begin gain = 9'd0;   bits = 4'd0;  end
            1: begin gain = 9'd256; bits = 4'd15; end
            2: begin gain = 9'd511; bits = 4'd1;  end
            3: begin gain = 9'd1;   bits = 4'd2;  end
            4: begin gain = 9'd255; bits = 4'd14; end
            5: begin gain = 9'd128; bits = 4'd3;  end
            default: begin
               gain = GAIN_W'($urandom_range(0, 511));
               bits = BITS_W'($urandom_range(0, 15));
            end
         endcase
         csr_write(REG_GAIN, CSR_DW'(gain));
         csr_write(REG_BITS, CSR_DW'(bits));
         no_idle = ($urandom_range(0, 3) == 0);
         if (phase == 2) begin
            saved = requests_sent;
            fill_ring();
            requests_sent = saved;
         end
         repeat (6) begin
            r = $urandom_range(0, 99);
            if (r < 65) play_stream();
            else if (r < 85) broken_stream();
            else noise_burst();
         end
         phase++;
      end
      settle();

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: audio_ring_pwm_player.f
sv/arpp_pkg.sv
sv/arpp_channels.sv
sv/arpp_csr.sv
sv/arpp_ctrl.sv
sv/arpp_dp.sv
sv/audio_ring_pwm_player.sv
tb/audio_ring_pwm_player_checker.sv
tb/audio_ring_pwm_player_test.sv
